>>> rtl/bpcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpcc_pkg
// Shared types and constants for the BER packet completeness check.
// ----------------------------------------------------------------------------
package bpcc_pkg;

  localparam logic [7:0]  TAG_BYTE         = 8'h30;
  localparam logic [31:0] COUNT_MAX        = 32'hFFFF_FFFF;
  localparam logic [31:0] CONTENT_SAT_LIM  = 32'h00FF_FFFF;
  localparam logic [31:0] MIN_BUFFER_BYTES = 32'd4;
  localparam logic [31:0] MAX_LEN_RESET    = 32'h0800_0000;

  typedef enum logic [1:0] {
    STATUS_INCOMPLETE = 2'd0,
    STATUS_ERROR      = 2'd1,
    STATUS_COMPLETE   = 2'd2
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] packet_length;
  } result_t;

endpackage : bpcc_pkg
`default_nettype wire

>>> rtl/bpcc_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpcc_parser
// Per-buffer header parse state and the end-of-buffer verdict logic.
// ----------------------------------------------------------------------------
module bpcc_parser
  import bpcc_pkg::*;
#(
  parameter int LENGTH_FIELD_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic        empty_buffer,
  input  wire logic [31:0] max_packet_len,
  output result_t          result
);

  localparam int LW = $clog2(LENGTH_FIELD_BYTES + 1);
  localparam int HW = $clog2(LENGTH_FIELD_BYTES + 3);
  localparam logic [6:0] LFB_LIMIT = 7'(LENGTH_FIELD_BYTES);

  logic [31:0] byte_position, byte_position_next;
  logic [LW-1:0] length_bytes_left, length_bytes_left_next;
  logic [HW-1:0] header_bytes, header_bytes_next;
  logic [31:0] content_bytes, content_bytes_next;
  logic header_complete, header_complete_next;
  logic error_seen, error_seen_next;
  logic beyond_packet_seen, beyond_packet_seen_next;
  logic length_form_bad, length_form_bad_next;

  logic [32:0] pkt_cur;
  logic [32:0] pkt_next;
  logic [6:0]  len_count;

  assign pkt_cur   = {1'b0, content_bytes} + 33'(header_bytes);
  assign pkt_next  = {1'b0, content_bytes_next} + 33'(header_bytes_next);
  assign len_count = data_byte[6:0];

  always_comb begin
    byte_position_next      = byte_position;
    length_bytes_left_next  = length_bytes_left;
    header_bytes_next       = header_bytes;
    content_bytes_next      = content_bytes;
    header_complete_next    = header_complete;
    error_seen_next         = error_seen;
    beyond_packet_seen_next = beyond_packet_seen;
    length_form_bad_next    = length_form_bad;

    // saturated count: byte is ignored entirely
    if (byte_position != COUNT_MAX) begin
      byte_position_next = byte_position + 32'd1;
      if (header_complete && ({1'b0, byte_position} == pkt_cur) &&
          (data_byte != TAG_BYTE)) begin
        beyond_packet_seen_next = 1'b1;
      end
      if (byte_position == 32'd0) begin
        if (data_byte != TAG_BYTE) begin
          error_seen_next = 1'b1;
        end
      end else if (byte_position == 32'd1) begin
        if (data_byte[7]) begin
          if (len_count > LFB_LIMIT) begin
            length_form_bad_next = 1'b1;
          end else begin
            header_bytes_next      = HW'(2) + HW'(len_count);
            length_bytes_left_next = LW'(len_count);
            if (len_count == 7'd0) begin
              header_complete_next = 1'b1;
            end
          end
        end else begin
          content_bytes_next   = {24'd0, data_byte};
          header_bytes_next    = HW'(2);
          header_complete_next = 1'b1;
        end
      end else if ((length_bytes_left != '0) && !length_form_bad) begin
        if (content_bytes > CONTENT_SAT_LIM) begin
          content_bytes_next = COUNT_MAX;
        end else begin
          content_bytes_next = {content_bytes[23:0], data_byte};
        end
        length_bytes_left_next = length_bytes_left - LW'(1);
        if (length_bytes_left == LW'(1)) begin
          header_complete_next = 1'b1;
        end
      end
    end
  end

  // verdict on the state as it stands after this byte
  always_comb begin
    result.status        = STATUS_INCOMPLETE;
    result.packet_length = 32'd0;
    if (empty_buffer) begin
      result.status = STATUS_INCOMPLETE;
    end else if (error_seen_next) begin
      result.status = STATUS_ERROR;
    end else if (byte_position_next < MIN_BUFFER_BYTES) begin
      result.status = STATUS_INCOMPLETE;
    end else if (length_form_bad_next) begin
      result.status = STATUS_ERROR;
    end else if (!header_complete_next) begin
      result.status = STATUS_INCOMPLETE;
    end else if (pkt_next > {1'b0, max_packet_len}) begin
      result.status = STATUS_ERROR;
    end else if ({1'b0, byte_position_next} > pkt_next) begin
      if (beyond_packet_seen_next) begin
        result.status = STATUS_ERROR;
      end else begin
        result.status        = STATUS_COMPLETE;
        result.packet_length = pkt_next[31:0];
      end
    end else if ({1'b0, byte_position_next} == pkt_next) begin
      result.status        = STATUS_COMPLETE;
      result.packet_length = pkt_next[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && (empty_buffer || last_byte))) begin
      byte_position      <= '0;
      length_bytes_left  <= '0;
      header_bytes       <= HW'(2);
      content_bytes      <= '0;
      header_complete    <= 1'b0;
      error_seen         <= 1'b0;
      beyond_packet_seen <= 1'b0;
      length_form_bad    <= 1'b0;
    end else if (step) begin
      byte_position      <= byte_position_next;
      length_bytes_left  <= length_bytes_left_next;
      header_bytes       <= header_bytes_next;
      content_bytes      <= content_bytes_next;
      header_complete    <= header_complete_next;
      error_seen         <= error_seen_next;
      beyond_packet_seen <= beyond_packet_seen_next;
      length_form_bad    <= length_form_bad_next;
    end
  end

endmodule : bpcc_parser
`default_nettype wire

>>> rtl/ber_packet_completeness_check_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ber_packet_completeness_check_core
// Checks a receive buffer, one byte per transaction, for a whole BER packet.
// ----------------------------------------------------------------------------
// Takes one byte every cycle while in_stall is low. Each accepted byte lands
// in an input register and is parsed from there; a verdict is produced for the
// last byte of a buffer (or an empty-buffer marker) and is captured in the
// result register. Bytes that end no buffer never wait on the output side;
// only a verdict that finds the result register still held by out_stall
// backs up into in_stall. max_packet_len is written via the cfg channel,
// which is always ready, and resets to 128 MiB.
// ----------------------------------------------------------------------------
module ber_packet_completeness_check_core
  import bpcc_pkg::*;
#(
  parameter int LENGTH_FIELD_BYTES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic        empty_buffer,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       status,
  output logic [31:0]      packet_length,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data
);

  logic        in_q_valid;
  logic [7:0]  data_q;
  logic        last_q;
  logic        empty_q;
  logic [31:0] max_packet_len;
  logic        emits;
  logic        advance;
  result_t     verdict;
  result_t     result_q;

  assign emits     = last_q || empty_q;
  assign advance   = in_q_valid && (!emits || !out_valid || !out_stall);
  assign in_stall  = in_q_valid && !advance;
  assign cfg_ready = 1'b1;

  bpcc_parser #(
    .LENGTH_FIELD_BYTES(LENGTH_FIELD_BYTES)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .data_byte     (data_q),
    .last_byte     (last_q),
    .empty_buffer  (empty_q),
    .max_packet_len(max_packet_len),
    .result        (verdict)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      data_q  <= data_byte;
      last_q  <= last_byte;
      empty_q <= empty_buffer;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emits) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance && emits) begin
      result_q <= verdict;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_packet_len <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_packet_len <= cfg_data;
    end
  end

  assign status        = result_q.status;
  assign packet_length = result_q.packet_length;

endmodule : ber_packet_completeness_check_core
`default_nettype wire
